>>> design/pbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_pkg: shared types and constants for the pileup base counter
// Table geometry, command and row formats, register map and IUPAC lookup.
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int REGION_LEN    = 4096;
  localparam int COUNT_BITS    = 16;
  localparam int IDX_BITS      = $clog2(REGION_LEN);
  localparam int POS_BITS      = 31;
  localparam int END_BITS      = POS_BITS + 1;
  localparam int QUAL_BITS     = 8;
  localparam int COVQ_BITS     = 16;
  localparam int RATIO_BITS    = 17;
  localparam int RATIO_FRAC    = 16;
  localparam int COV_BITS      = COUNT_BITS + 3;
  localparam int DEPTH_BITS    = COUNT_BITS + 2;
  localparam int THR_BITS      = DEPTH_BITS + RATIO_BITS;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int IN_USER_BITS  = 2;
  localparam int IN_DATA_BITS  = 72;
  localparam int OUT_DATA_BITS = 112;

  localparam logic [QUAL_BITS-1:0] QUAL_MAX_STD = 8'd254;
  localparam logic [QUAL_BITS-1:0] QUAL_MAX_ALL = 8'd255;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_STEP    = 2'd1,
    OP_READOUT = 2'd2
  } opcode_t;

  localparam logic [3:0] CIG_M  = 4'd0;
  localparam logic [3:0] CIG_D  = 4'd2;
  localparam logic [3:0] CIG_N  = 4'd3;
  localparam logic [3:0] CIG_EQ = 4'd7;
  localparam logic [3:0] CIG_X  = 4'd8;

  localparam logic [3:0] BASE_A = 4'd1;
  localparam logic [3:0] BASE_C = 4'd2;
  localparam logic [3:0] BASE_G = 4'd4;
  localparam logic [3:0] BASE_T = 4'd8;
  localparam logic [3:0] BASE_N = 4'd15;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_REGION_START = 3'd0,
    REG_REGION_END   = 3'd1,
    REG_MIN_MAPQ     = 3'd2,
    REG_MIN_BASEQ    = 3'd3,
    REG_INCL_MISSING = 3'd4,
    REG_MIN_COV      = 3'd5,
    REG_MAX_COV      = 3'd6,
    REG_RATIO        = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SEL_A, SEL_C, SEL_G, SEL_T, SEL_N, SEL_DEL
  } cnt_sel_t;

  typedef enum logic {
    CMD_BUMP, CMD_READOUT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    cnt_sel_t             sel;
    logic                 in_range;
    logic [IDX_BITS-1:0]  idx;
  } cmd_t;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam cnt_t CNT_MAX = '1;

  typedef struct packed {
    cnt_t del;
    cnt_t n;
    cnt_t t;
    cnt_t g;
    cnt_t c;
    cnt_t a;
  } row_t;

  typedef struct packed {
    logic [POS_BITS-1:0]   region_start;
    logic [POS_BITS-1:0]   region_end;
    logic [END_BITS-1:0]   eff_end;
    logic [QUAL_BITS-1:0]  min_mapq;
    logic [QUAL_BITS-1:0]  min_baseq;
    logic [1:0]            incl_missing;
    logic [COVQ_BITS-1:0]  min_cov;
    logic [COVQ_BITS-1:0]  max_cov;
    logic [RATIO_BITS-1:0] ratio;
  } cfg_t;

  localparam logic [6:0] CH_A = 7'h41;
  localparam logic [6:0] CH_B = 7'h42;
  localparam logic [6:0] CH_C = 7'h43;
  localparam logic [6:0] CH_D = 7'h44;
  localparam logic [6:0] CH_G = 7'h47;
  localparam logic [6:0] CH_H = 7'h48;
  localparam logic [6:0] CH_K = 7'h4B;
  localparam logic [6:0] CH_M = 7'h4D;
  localparam logic [6:0] CH_N = 7'h4E;
  localparam logic [6:0] CH_R = 7'h52;
  localparam logic [6:0] CH_S = 7'h53;
  localparam logic [6:0] CH_T = 7'h54;
  localparam logic [6:0] CH_V = 7'h56;
  localparam logic [6:0] CH_W = 7'h57;
  localparam logic [6:0] CH_Y = 7'h59;

  function automatic logic [6:0] iupac_char(input logic [3:0] mask);
    logic [6:0] ch;
    unique case (mask)
      4'h0: ch = CH_N;
      4'h1: ch = CH_A;
      4'h2: ch = CH_C;
      4'h3: ch = CH_M;
      4'h4: ch = CH_G;
      4'h5: ch = CH_R;
      4'h6: ch = CH_S;
      4'h7: ch = CH_V;
      4'h8: ch = CH_T;
      4'h9: ch = CH_W;
      4'hA: ch = CH_Y;
      4'hB: ch = CH_H;
      4'hC: ch = CH_K;
      4'hD: ch = CH_D;
      4'hE: ch = CH_B;
      4'hF: ch = CH_N;
    endcase
    return ch;
  endfunction

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? v : v + cnt_t'(1);
  endfunction

  // last counted position: region_end clipped to the table size
  function automatic logic [END_BITS-1:0] calc_eff_end(input logic [POS_BITS-1:0] start,
                                                       input logic [POS_BITS-1:0] last);
    logic [END_BITS-1:0] lim;
    lim = END_BITS'(start) + END_BITS'(REGION_LEN - 1);
    return (END_BITS'(last) < lim) ? END_BITS'(last) : lim;
  endfunction

endpackage

>>> design/pbc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_cfg: configuration register file
// Holds the eight settings and the clipped end of the counted region.
// ----------------------------------------------------------------------------
module pbc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pbc_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [pbc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output pbc_pkg::cfg_t                    cfg
);
  import pbc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_REGION_START: cfg_nxt.region_start = cfg_data[POS_BITS-1:0];
        REG_REGION_END:   cfg_nxt.region_end   = cfg_data[POS_BITS-1:0];
        REG_MIN_MAPQ:     cfg_nxt.min_mapq     = cfg_data[QUAL_BITS-1:0];
        REG_MIN_BASEQ:    cfg_nxt.min_baseq    = cfg_data[QUAL_BITS-1:0];
        REG_INCL_MISSING: cfg_nxt.incl_missing = cfg_data[1:0];
        REG_MIN_COV:      cfg_nxt.min_cov      = cfg_data[COVQ_BITS-1:0];
        REG_MAX_COV:      cfg_nxt.max_cov      = cfg_data[COVQ_BITS-1:0];
        REG_RATIO:        cfg_nxt.ratio        = cfg_data[RATIO_BITS-1:0];
      endcase
    end
    cfg_nxt.eff_end = calc_eff_end(cfg_nxt.region_start, cfg_nxt.region_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.region_start <= POS_BITS'(1);
      cfg_r.region_end   <= POS_BITS'(4096);
      cfg_r.eff_end      <= calc_eff_end(POS_BITS'(1), POS_BITS'(4096));
      cfg_r.min_mapq     <= '0;
      cfg_r.min_baseq    <= '0;
      cfg_r.incl_missing <= '0;
      cfg_r.min_cov      <= '0;
      cfg_r.max_cov      <= COVQ_BITS'(9999);
      cfg_r.ratio        <= RATIO_BITS'(16384);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> design/pbc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_front: item decode and read walker
// Tracks the current read's position and acceptance, turns each item into
// at most one table command for the back end.
// ----------------------------------------------------------------------------
module pbc_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pbc_pkg::IN_USER_BITS-1:0] in_tuser,
  input  logic [pbc_pkg::IN_DATA_BITS-1:0] in_tdata,
  input  pbc_pkg::cfg_t                    cfg,
  input  logic                             q_full,
  input  logic                             clr_busy,
  output logic                             q_push,
  output pbc_pkg::cmd_t                    q_cmd
);
  import pbc_pkg::*;

  logic [POS_BITS-1:0]  next_pos_r, next_pos_nxt;
  logic                 acc_r, acc_nxt;

  opcode_t              op;
  logic [POS_BITS-1:0]  rd_pos;
  logic [QUAL_BITS-1:0] mapq;
  logic [3:0]           cig;
  logic [3:0]           base;
  logic [QUAL_BITS-1:0] baseq;
  logic [11:0]          ro_idx;

  logic accept, is_match, is_del, pos_past, at_end, in_region, mq_ok, bq_ok;

  // tdata: read_position, map_quality, cigar_op, base_code, base_quality,
  // readout_index from bit 0 up
  assign op     = opcode_t'(in_tuser);
  assign rd_pos = in_tdata[30:0];
  assign mapq   = in_tdata[38:31];
  assign cig    = in_tdata[42:39];
  assign base   = in_tdata[46:43];
  assign baseq  = in_tdata[54:47];
  assign ro_idx = in_tdata[66:55];

  assign in_tready = !q_full && !clr_busy;
  assign accept    = in_tvalid && in_tready;

  assign is_match  = (cig == CIG_M) || (cig == CIG_EQ) || (cig == CIG_X);
  assign is_del    = (cig == CIG_D) || (cig == CIG_N);
  assign pos_past  = END_BITS'(next_pos_r) >  cfg.eff_end;
  assign at_end    = END_BITS'(next_pos_r) >= cfg.eff_end;
  assign in_region = next_pos_r >= cfg.region_start;
  assign mq_ok     = (mapq >= cfg.min_mapq) &&
                     (mapq <= (cfg.incl_missing[0] ? QUAL_MAX_ALL : QUAL_MAX_STD));
  assign bq_ok     = (baseq >= cfg.min_baseq) &&
                     (baseq <= (cfg.incl_missing[1] ? QUAL_MAX_ALL : QUAL_MAX_STD));

  always_comb begin
    next_pos_nxt   = next_pos_r;
    acc_nxt        = acc_r;
    q_push         = 1'b0;
    q_cmd.kind     = CMD_BUMP;
    q_cmd.sel      = SEL_DEL;
    q_cmd.in_range = 1'b1;
    q_cmd.idx      = IDX_BITS'(next_pos_r - cfg.region_start);
    if (accept) begin
      unique case (op)
        OP_START: begin
          next_pos_nxt = rd_pos;
          acc_nxt      = mq_ok;
        end
        OP_STEP: begin
          if (acc_r && (is_match || is_del)) begin
            if (pos_past) begin
              acc_nxt = 1'b0;
            end else begin
              if (in_region) begin
                if (is_del) begin
                  q_push = 1'b1;
                end else if (bq_ok) begin
                  unique case (base)
                    BASE_A: begin q_push = 1'b1; q_cmd.sel = SEL_A; end
                    BASE_C: begin q_push = 1'b1; q_cmd.sel = SEL_C; end
                    BASE_G: begin q_push = 1'b1; q_cmd.sel = SEL_G; end
                    BASE_T: begin q_push = 1'b1; q_cmd.sel = SEL_T; end
                    BASE_N: begin q_push = 1'b1; q_cmd.sel = SEL_N; end
                    default: ;  // other ambiguity codes only advance
                  endcase
                end
              end
              if (at_end) begin
                acc_nxt = 1'b0;
              end else begin
                next_pos_nxt = next_pos_r + POS_BITS'(1);
              end
            end
          end
        end
        OP_READOUT: begin
          q_push         = 1'b1;
          q_cmd.kind     = CMD_READOUT;
          q_cmd.idx      = IDX_BITS'(ro_idx);
          q_cmd.in_range = 32'(ro_idx) < 32'(REGION_LEN);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_pos_r <= POS_BITS'(1);
      acc_r      <= 1'b0;
    end else begin
      next_pos_r <= next_pos_nxt;
      acc_r      <= acc_nxt;
    end
  end

endmodule

>>> design/pbc_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_cmd_fifo: command queue between front and back
// Small register FIFO with full and empty flags.
// ----------------------------------------------------------------------------
module pbc_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pbc_pkg::cmd_t push_cmd,
  input  logic          pop,
  output pbc_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import pbc_pkg::*;

  cmd_t                     entries [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_PTR_BITS:0]   count_r;

  assign head  = entries[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> design/pbc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_back: count table and readout engine
// Runs each queued command as a read-modify-write of one table row; a
// readout also filters, scales the threshold and forms the IUPAC code.
// ----------------------------------------------------------------------------
module pbc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pbc_pkg::cfg_t                     cfg,
  input  pbc_pkg::cmd_t                     head,
  input  logic                              q_empty,
  output logic                              q_pop,
  output logic                              clr_busy,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pbc_pkg::OUT_DATA_BITS-1:0] out_tdata
);
  import pbc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_MODIFY, ST_MUL, ST_DONE
  } state_t;

  state_t                    state_r;
  logic [IDX_BITS-1:0]       clr_idx_r;
  cmd_t                      cmd_r;
  row_t                      mem [REGION_LEN];
  row_t                      mem_rdata_r;
  cnt_t                      a_r, c_r, g_r, t_r, n_r, d_r;
  logic [THR_BITS-1:0]       thr_r;
  logic                      nz_r;
  logic                      out_valid_r;
  logic [OUT_DATA_BITS-1:0]  out_data_r;

  logic                      mem_we;
  logic [IDX_BITS-1:0]       mem_waddr;
  row_t                      mem_wdata;
  row_t                      row_cur;
  logic [COV_BITS-1:0]       cov;
  logic                      cov_ok;
  logic [DEPTH_BITS-1:0]     depth;
  logic [THR_BITS-1:0]       prod;
  logic [3:0]                mask;
  logic                      out_load;

  assign clr_busy   = (state_r == ST_CLEAR);
  assign q_pop      = (state_r == ST_IDLE) && !q_empty;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // an index beyond the table reads as an empty row
  assign row_cur = cmd_r.in_range ? mem_rdata_r : '0;
  assign cov     = COV_BITS'(row_cur.a) + COV_BITS'(row_cur.c) + COV_BITS'(row_cur.g) +
                   COV_BITS'(row_cur.t) + COV_BITS'(row_cur.n);
  assign cov_ok  = (cov >= COV_BITS'(cfg.min_cov)) && (cov <= COV_BITS'(cfg.max_cov));
  assign depth   = DEPTH_BITS'(a_r) + DEPTH_BITS'(c_r) + DEPTH_BITS'(g_r) + DEPTH_BITS'(t_r);
  assign prod    = THR_BITS'(depth) * THR_BITS'(cfg.ratio);

  always_comb begin
    mask[0] = THR_BITS'({a_r, RATIO_FRAC'(0)}) > thr_r;
    mask[1] = THR_BITS'({c_r, RATIO_FRAC'(0)}) > thr_r;
    mask[2] = THR_BITS'({g_r, RATIO_FRAC'(0)}) > thr_r;
    mask[3] = THR_BITS'({t_r, RATIO_FRAC'(0)}) > thr_r;
    if (!nz_r) begin
      mask = 4'h0;
    end
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cmd_r.idx;
    mem_wdata = mem_rdata_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
      end
      ST_MODIFY: begin
        if (cmd_r.kind == CMD_BUMP) begin
          mem_we = 1'b1;
          unique case (cmd_r.sel)
            SEL_A:   mem_wdata.a   = sat_inc(mem_rdata_r.a);
            SEL_C:   mem_wdata.c   = sat_inc(mem_rdata_r.c);
            SEL_G:   mem_wdata.g   = sat_inc(mem_rdata_r.g);
            SEL_T:   mem_wdata.t   = sat_inc(mem_rdata_r.t);
            SEL_N:   mem_wdata.n   = sat_inc(mem_rdata_r.n);
            SEL_DEL: mem_wdata.del = sat_inc(mem_rdata_r.del);
            default: ;
          endcase
        end else begin
          mem_we    = cmd_r.in_range;
          mem_wdata = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[head.idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == IDX_BITS'(REGION_LEN - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            cmd_r   <= head;
            state_r <= ST_MODIFY;
          end
        end
        ST_MODIFY: begin
          if (cmd_r.kind == CMD_BUMP) begin
            state_r <= ST_IDLE;
          end else begin
            a_r     <= cov_ok ? row_cur.a : '0;
            c_r     <= cov_ok ? row_cur.c : '0;
            g_r     <= cov_ok ? row_cur.g : '0;
            t_r     <= cov_ok ? row_cur.t : '0;
            n_r     <= cov_ok ? row_cur.n : '0;
            d_r     <= row_cur.del;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          thr_r   <= prod;
          nz_r    <= (depth != '0);
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            out_data_r  <= OUT_DATA_BITS'({iupac_char(mask), mask,
                                           d_r, n_r, t_r, g_r, c_r, a_r});
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> design/pileup_base_counter_iupac_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pileup_base_counter_iupac_core: pileup base counter with IUPAC readout
// Counts A/C/G/T/N and deletions per position of one region from a stream
// of read starts and cigar steps; a readout returns and clears one position.
// ----------------------------------------------------------------------------
// After reset the table is swept to zero, one row per cycle; in_tready stays
// low for that time while configuration writes are taken.
// A start-read item, an ignored item or a step that counts nothing ends in
// the front end and queues no command. A counting step is one
// read-modify-write of a count table row in the back end. A readout runs
// the back-end steps table read, coverage filter, threshold multiply and
// compare, plus any wait for out_tready. A 4-deep command queue lets the front
// keep taking items while the back end works; the back end sets the sustained
// rate and takes the next command only once it is done with the last.
module pileup_base_counter_iupac_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tuser: opcode
  input  logic [pbc_pkg::IN_USER_BITS-1:0]  in_tuser,
  // in_tdata: read_position[30:0], map_quality[38:31], cigar_op[42:39],
  // base_code[46:43], base_quality[54:47], readout_index[66:55], zero fill
  input  logic [pbc_pkg::IN_DATA_BITS-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: count_a_out[15:0], count_c_out[31:16], count_g_out[47:32],
  // count_t_out[63:48], count_n_out[79:64], count_del_out[95:80],
  // iupac_mask[99:96], iupac_char[106:100], zero fill
  output logic [pbc_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pbc_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [pbc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import pbc_pkg::*;

  cfg_t cfg;
  cmd_t q_cmd, q_head;
  logic q_push, q_pop, q_empty, q_full, clr_busy;

  pbc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg       (cfg),
    .q_full    (q_full),
    .clr_busy  (clr_busy),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  pbc_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  pbc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .clr_busy   (clr_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> design/pbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_checker: port-level checks for the pileup base counter
// Watches the top-level ports and is bound to every instance of the core.
// ----------------------------------------------------------------------------
module pbc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [pbc_pkg::OUT_DATA_BITS-1:0] out_tdata
);
  import pbc_pkg::*;

  // a result that waits keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // the clearing sweep keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_tready)
    else $error("input open before table clear");

  // an empty mask reads as N
  a_empty_mask_n: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[99:96] == 4'h0) |-> (out_tdata[106:100] == CH_N))
    else $error("empty mask without N");

  // an A bit needs a nonzero A count
  a_mask_a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[96] |-> (out_tdata[15:0] != 16'h0))
    else $error("A in mask with zero A count");

endmodule

bind pileup_base_counter_iupac_core pbc_checker u_pbc_checker (.*);

>>> tb/tb_pileup_base_counter_iupac_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pileup_base_counter_iupac_core: self-checking bench for the pileup counter
// Drives read starts, cigar steps and readouts with random bursts and gaps.
// A scoreboard keeps its own count table and predicts every readout row.
// It covers directed corner cases, back-to-back reads on one entry, a long
// output hold-off and random read streams over several register settings.
// ----------------------------------------------------------------------------
module tb_pileup_base_counter_iupac_core;
  import pbc_pkg::*;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [3:0] CIG_I      = 4'd1;
  localparam logic [3:0] CIG_UNUSED = 4'd12;
  localparam logic [3:0] BASE_R     = 4'd5;
  localparam logic [POS_BITS-1:0] POS_TOP = 31'h7FFF_FFFF;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int BURST_READS   = 20;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    logic [1:0]           op;
    logic [POS_BITS-1:0]  pos;
    logic [QUAL_BITS-1:0] mapq;
    logic [3:0]           cig;
    logic [3:0]           base;
    logic [QUAL_BITS-1:0] bq;
    logic [IDX_BITS-1:0]  ridx;
  } pile_item_t;

  typedef struct {
    row_t       counts;
    logic [3:0] mask;
    logic [6:0] letter;
  } pile_row_t;

  class pileup_scoreboard;
    cnt_t                  tally [6][REGION_LEN];
    logic [POS_BITS-1:0]   rstart, rend, next_pos;
    logic [QUAL_BITS-1:0]  min_mapq, min_bq;
    logic [1:0]            incl;
    logic [COVQ_BITS-1:0]  min_cov, max_cov;
    logic [RATIO_BITS-1:0] ratio;
    bit                    accepted;
    pile_row_t             expected_rows[$];
    int                    mismatches;
    int                    rows_checked;
    string                 letters;

    function new();
      rstart   = 1;
      rend     = 4096;
      min_mapq = 0;
      min_bq   = 0;
      incl     = 0;
      min_cov  = 0;
      max_cov  = 9999;
      ratio    = 16384;
      next_pos = 1;
      accepted = 0;
      letters  = "NACMGRSVTWYHKDBN";
      foreach (tally[s, i]) tally[s][i] = '0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_DATA_BITS-1:0] v);
      case (r)
        REG_REGION_START: rstart   = v[POS_BITS-1:0];
        REG_REGION_END:   rend     = v[POS_BITS-1:0];
        REG_MIN_MAPQ:     min_mapq = v[QUAL_BITS-1:0];
        REG_MIN_BASEQ:    min_bq   = v[QUAL_BITS-1:0];
        REG_INCL_MISSING: incl     = v[1:0];
        REG_MIN_COV:      min_cov  = v[COVQ_BITS-1:0];
        REG_MAX_COV:      max_cov  = v[COVQ_BITS-1:0];
        REG_RATIO:        ratio    = v[RATIO_BITS-1:0];
        default: ;
      endcase
    endfunction

    // last counted position: region end clipped to the table size
    function longint last_pos();
      longint lim;
      lim = longint'(rstart) + longint'(REGION_LEN - 1);
      return (longint'(rend) < lim) ? longint'(rend) : lim;
    endfunction

    function void bump(int s, int idx);
      if (tally[s][idx] != CNT_MAX) tally[s][idx] = tally[s][idx] + 1'b1;
    endfunction

    function void count_step(pile_item_t it);
      bit         is_match, is_del;
      longint     p, eend;
      int         idx;
      logic [7:0] bmax;
      is_match = (it.cig == CIG_M) || (it.cig == CIG_EQ) || (it.cig == CIG_X);
      is_del   = (it.cig == CIG_D) || (it.cig == CIG_N);
      eend     = last_pos();
      p        = longint'(next_pos);
      if (!accepted || !(is_match || is_del)) return;
      if (p > eend) begin
        accepted = 0;
        return;
      end
      if (p >= longint'(rstart)) begin
        idx  = int'(p - longint'(rstart));
        bmax = incl[1] ? QUAL_MAX_ALL : QUAL_MAX_STD;
        if (is_del) begin
          bump(SEL_DEL, idx);
        end else if (it.bq >= min_bq && it.bq <= bmax) begin
          case (it.base)
            BASE_A: bump(SEL_A, idx);
            BASE_C: bump(SEL_C, idx);
            BASE_G: bump(SEL_G, idx);
            BASE_T: bump(SEL_T, idx);
            BASE_N: bump(SEL_N, idx);
            default: ;
          endcase
        end
      end
      if (p >= eend) accepted = 0;
      else next_pos = POS_BITS'(p + 1);
    endfunction

    function void read_out(logic [IDX_BITS-1:0] idx);
      pile_row_t  r;
      longint     cov, depth, thr;
      logic [3:0] m;
      byte        ch;
      r.counts = '0;
      if (idx < REGION_LEN) begin
        r.counts.a   = tally[SEL_A][idx];
        r.counts.c   = tally[SEL_C][idx];
        r.counts.g   = tally[SEL_G][idx];
        r.counts.t   = tally[SEL_T][idx];
        r.counts.n   = tally[SEL_N][idx];
        r.counts.del = tally[SEL_DEL][idx];
        for (int s = 0; s < 6; s++) tally[s][idx] = '0;
      end
      cov = longint'(r.counts.a) + longint'(r.counts.c) + longint'(r.counts.g) +
            longint'(r.counts.t) + longint'(r.counts.n);
      if (cov < longint'(min_cov) || cov > longint'(max_cov)) begin
        r.counts.a = '0;
        r.counts.c = '0;
        r.counts.g = '0;
        r.counts.t = '0;
        r.counts.n = '0;
      end
      depth = longint'(r.counts.a) + longint'(r.counts.c) + longint'(r.counts.g) +
              longint'(r.counts.t);
      m = '0;
      if (depth != 0) begin
        thr = depth * longint'(ratio);
        if ((longint'(r.counts.a) << RATIO_FRAC) > thr) m[0] = 1'b1;
        if ((longint'(r.counts.c) << RATIO_FRAC) > thr) m[1] = 1'b1;
        if ((longint'(r.counts.g) << RATIO_FRAC) > thr) m[2] = 1'b1;
        if ((longint'(r.counts.t) << RATIO_FRAC) > thr) m[3] = 1'b1;
      end
      ch       = letters[m];
      r.mask   = m;
      r.letter = ch[6:0];
      expected_rows = {expected_rows, r};
    endfunction

    function void note_input(pile_item_t it);
      logic [7:0] mmax;
      case (it.op)
        OP_START: begin
          mmax     = incl[0] ? QUAL_MAX_ALL : QUAL_MAX_STD;
          next_pos = it.pos;
          accepted = (it.mapq >= min_mapq) && (it.mapq <= mmax);
        end
        OP_STEP:    count_step(it);
        OP_READOUT: read_out(it.ridx);
        default: ;
      endcase
    endfunction

    function void check_row(logic [OUT_DATA_BITS-1:0] td);
      pile_row_t got, want;
      got.counts.a   = td[15:0];
      got.counts.c   = td[31:16];
      got.counts.g   = td[47:32];
      got.counts.t   = td[63:48];
      got.counts.n   = td[79:64];
      got.counts.del = td[95:80];
      got.mask       = td[99:96];
      got.letter     = td[106:100];
      rows_checked++;
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected row: A/C/G/T/N/D %0d/%0d/%0d/%0d/%0d/%0d mask %h '%c'",
                   got.counts.a, got.counts.c, got.counts.g, got.counts.t,
                   got.counts.n, got.counts.del, got.mask, got.letter);
        return;
      end
      want = expected_rows.pop_front();
      if (got.counts.a !== want.counts.a || got.counts.c !== want.counts.c ||
          got.counts.g !== want.counts.g || got.counts.t !== want.counts.t ||
          got.counts.n !== want.counts.n || got.counts.del !== want.counts.del ||
          got.mask !== want.mask || got.letter !== want.letter) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("row %0d mismatch: exp A/C/G/T/N/D %0d/%0d/%0d/%0d/%0d/%0d mask %h '%c'",
                   rows_checked, want.counts.a, want.counts.c, want.counts.g,
                   want.counts.t, want.counts.n, want.counts.del, want.mask, want.letter);
          $display("             got A/C/G/T/N/D %0d/%0d/%0d/%0d/%0d/%0d mask %h '%c'",
                   got.counts.a, got.counts.c, got.counts.g, got.counts.t,
                   got.counts.n, got.counts.del, got.mask, got.letter);
        end
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [IN_USER_BITS-1:0]  in_tuser   = '0;
  logic [IN_DATA_BITS-1:0]  in_tdata   = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [CFG_ADDR_BITS-1:0] cfg_addr   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data   = '0;

  pileup_scoreboard sb = new();
  bit hold_req   = 1'b0;
  bit paced      = 1'b1;
  int burst_left = 0;
  int sent_items = 0;

  pileup_base_counter_iupac_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("pileup_base_counter_iupac_core verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_row(out_tdata);
  end

  // output back-pressure: random runs, long ready stretches, one long hold-off
  initial begin : rx_pattern
    bit level;
    int run_left;
    level    = 1'b1;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (run_left == 0) begin
          case ($urandom_range(0, 5))
            0: begin
              level    = 1'b1;
              run_left = $urandom_range(40, 80);
            end
            1, 2: begin
              level    = 1'b0;
              run_left = $urandom_range(1, 12);
            end
            default: begin
              level    = 1'b1;
              run_left = $urandom_range(1, 6);
            end
          endcase
        end
        out_tready <= level;
        run_left--;
      end
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_BITS-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(r, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [POS_BITS-1:0] rs, logic [POS_BITS-1:0] re,
                           logic [7:0] mq, logic [7:0] bq, logic [1:0] inc,
                           logic [15:0] mnc, logic [15:0] mxc, logic [16:0] rat);
    write_reg(REG_REGION_START, CFG_DATA_BITS'(rs));
    write_reg(REG_REGION_END,   CFG_DATA_BITS'(re));
    write_reg(REG_MIN_MAPQ,     CFG_DATA_BITS'(mq));
    write_reg(REG_MIN_BASEQ,    CFG_DATA_BITS'(bq));
    write_reg(REG_INCL_MISSING, CFG_DATA_BITS'(inc));
    write_reg(REG_MIN_COV,      CFG_DATA_BITS'(mnc));
    write_reg(REG_MAX_COV,      CFG_DATA_BITS'(mxc));
    write_reg(REG_RATIO,        CFG_DATA_BITS'(rat));
  endtask

  task automatic send_item(pile_item_t it);
    int gap;
    if (paced) begin
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left--;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {5'b0, it.ridx, it.bq, it.base, it.cig, it.mapq, it.pos};
    do @(posedge clk); while (!in_tready);
    sb.note_input(it);
    if (it.op != OP_IGNORED) sent_items++;
  endtask

  // stop offering, wait out every pending row, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic pile_item_t noise_item();
    pile_item_t it;
    it.op   = 2'($urandom_range(0, 3));
    it.pos  = POS_BITS'($urandom);
    if (it.pos == 0) it.pos = 1;
    it.mapq = 8'($urandom);
    it.cig  = 4'($urandom);
    it.base = 4'($urandom);
    it.bq   = 8'($urandom);
    it.ridx = IDX_BITS'($urandom);
    return it;
  endfunction

  function automatic pile_item_t make_start(logic [POS_BITS-1:0] p, logic [7:0] q);
    pile_item_t it;
    it      = noise_item();
    it.op   = OP_START;
    it.pos  = p;
    it.mapq = q;
    return it;
  endfunction

  function automatic pile_item_t make_step(logic [3:0] c, logic [3:0] b, logic [7:0] q);
    pile_item_t it;
    it      = noise_item();
    it.op   = OP_STEP;
    it.cig  = c;
    it.base = b;
    it.bq   = q;
    return it;
  endfunction

  function automatic pile_item_t make_readout(logic [IDX_BITS-1:0] idx);
    pile_item_t it;
    it      = noise_item();
    it.op   = OP_READOUT;
    it.ridx = idx;
    return it;
  endfunction

  // mostly inside the acceptance window, sometimes anywhere
  function automatic logic [7:0] qual_pick(int lo, int hi);
    if (lo <= hi && $urandom_range(0, 9) < 8) return 8'($urandom_range(hi, lo));
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic logic [IDX_BITS-1:0] near_idx(longint hot_off);
    longint ri;
    if ($urandom_range(0, 9) == 0) return IDX_BITS'($urandom);
    ri = hot_off + longint'($urandom_range(0, 10)) - 3;
    if (ri < 0) ri = 0;
    if (ri > REGION_LEN - 1) ri = REGION_LEN - 1;
    return IDX_BITS'(ri);
  endfunction

  // one read: start near the hot spot, then a short cigar run
  task automatic send_read(longint hot_pos);
    longint     p;
    int         r, rb;
    logic [3:0] c, b;
    p = hot_pos + longint'($urandom_range(0, 10)) - 8;
    if (p < 1) p = 1;
    if (p > longint'(POS_TOP)) p = longint'(POS_TOP);
    send_item(make_start(POS_BITS'(p),
                         qual_pick(sb.min_mapq, sb.incl[0] ? 255 : 254)));
    repeat ($urandom_range(1, 12)) begin
      r  = $urandom_range(0, 19);
      rb = $urandom_range(0, 19);
      if (r < 10) c = CIG_M;
      else if (r < 12) c = CIG_EQ;
      else if (r < 14) c = CIG_X;
      else if (r < 16) c = CIG_D;
      else if (r < 17) c = CIG_N;
      else c = 4'($urandom);
      if (rb < 4) b = BASE_A;
      else if (rb < 8) b = BASE_C;
      else if (rb < 12) b = BASE_G;
      else if (rb < 15) b = BASE_T;
      else if (rb < 17) b = BASE_N;
      else b = 4'($urandom);
      send_item(make_step(c, b, qual_pick(sb.min_bq, sb.incl[1] ? 255 : 254)));
    end
  endtask

  task automatic random_phase(int n_items, bit with_hold);
    longint eend, span, hot_off, hot_pos;
    int     first, r;
    bit     held;
    eend  = sb.last_pos();
    span  = (eend >= longint'(sb.rstart)) ? eend - longint'(sb.rstart) + 1 : 1;
    first = sent_items;
    held  = 1'b0;
    hot_off = longint'($urandom_range(32'(span - 1), 0));
    hot_pos = longint'(sb.rstart) + hot_off;
    while (sent_items - first < n_items) begin
      if (with_hold && !held && sent_items - first >= n_items / 2) begin
        // stall the output long enough for the command queue to back up
        held     = 1'b1;
        hold_req = 1'b1;
        paced    = 1'b0;
        repeat (12) send_item(make_readout(near_idx(hot_off)));
        paced = 1'b1;
        drain();
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
        send_read(hot_pos);
      end else if (r < 85) begin
        repeat ($urandom_range(1, 3)) send_item(make_readout(near_idx(hot_off)));
      end else if (r < 95) begin
        send_item(noise_item());
      end else begin
        // orphan steps after the read has closed or been skipped
        repeat ($urandom_range(1, 3)) send_item(make_step(CIG_M, BASE_A, 8'd30));
      end
      if ($urandom_range(0, 9) == 0) begin
        hot_off = longint'($urandom_range(32'(span - 1), 0));
        hot_pos = longint'(sb.rstart) + hot_off;
      end
    end
    drain();
  endtask

  initial begin : stimulus
    logic [POS_BITS-1:0] rs, re;
    longint              tmp;
    pile_item_t          it;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // registers are taken while the table is still being swept
    write_all(31'd100, 31'd4195, 8'd20, 8'd10, 2'd0, 16'd0, 16'd9999, 17'd16384);

    send_item(make_step(CIG_M, BASE_A, 8'd30));     // no read open yet
    send_item(make_readout(12'd0));                 // empty entry
    send_item(make_start(31'd100, 8'd255));         // mapq over the 254 limit
    send_item(make_step(CIG_M, BASE_A, 8'd30));
    send_item(make_start(31'd99, 8'd20));           // mapq at its minimum
    send_item(make_step(CIG_I, BASE_C, 8'd30));
    send_item(make_step(CIG_EQ, BASE_C, 8'd10));    // before region start
    send_item(make_step(CIG_X, BASE_G, 8'd254));
    send_item(make_step(CIG_M, BASE_T, 8'd255));    // bq over the limit
    send_item(make_step(CIG_D, BASE_A, 8'd0));
    send_item(make_step(CIG_N, BASE_A, 8'd0));
    send_item(make_step(CIG_M, BASE_R, 8'd40));     // ambiguity code
    send_item(make_step(CIG_M, BASE_N, 8'd9));      // bq under minimum
    send_item(make_step(CIG_M, BASE_N, 8'd40));
    send_item(make_step(CIG_UNUSED, BASE_A, 8'd40));
    it    = noise_item();
    it.op = OP_IGNORED;
    send_item(it);
    send_item(make_readout(12'd0));
    send_item(make_readout(12'd2));
    send_item(make_readout(12'd6));                 // N only: zero depth
    send_item(make_start(31'd4195, 8'd254));        // last counted position
    send_item(make_step(CIG_M, BASE_A, 8'd30));
    send_item(make_step(CIG_M, BASE_A, 8'd30));     // read already closed
    send_item(make_readout(12'd4095));
    send_item(make_start(31'd5000, 8'd100));        // past the effective end
    send_item(make_step(CIG_M, BASE_C, 8'd30));
    drain();

    // back-to-back reads onto one entry, coverage right at both limits
    write_all(31'd7, 31'd107, 8'd0, 8'd0, 2'd3, 16'd20, 16'd20, 17'd65536);
    paced = 1'b0;
    repeat (BURST_READS) begin
      send_item(make_start(31'd7, 8'd255));
      send_item(make_step(CIG_M, BASE_A, 8'd255));
    end
    send_item(make_readout(12'd0));
    paced = 1'b1;
    drain();

    write_all(31'd1, 31'd4096, 8'd0, 8'd0, 2'd3, 16'd0, 16'd65535, 17'd0);
    random_phase(70, 1'b1);

    write_all(POS_TOP - 31'd4095, POS_TOP, 8'($urandom_range(60, 0)),
              8'($urandom_range(40, 0)), 2'd0, 16'd1, 16'd9999, 17'd65536);
    random_phase(70, 1'b0);

    rs = POS_BITS'($urandom_range(32'(POS_TOP) - 40, 1));
    write_all(rs, rs + POS_BITS'($urandom_range(30, 0)), 8'd30, 8'd20, 2'd1,
              16'd2, 16'd6, 17'd16384);
    random_phase(70, 1'b0);

    write_all(POS_TOP, POS_TOP, 8'd255, 8'd255, 2'd3, 16'd0, 16'd65535,
              17'($urandom_range(65536, 0)));
    random_phase(50, 1'b0);

    rs  = POS_BITS'($urandom_range(32'(POS_TOP), 1));
    tmp = longint'(rs) + longint'($urandom_range(5010, 0)) - 10;
    if (tmp < 1) tmp = 1;
    if (tmp > longint'(POS_TOP)) tmp = longint'(POS_TOP);
    re = POS_BITS'(tmp);
    write_all(rs, re, 8'($urandom), 8'($urandom), 2'($urandom),
              16'($urandom_range(3, 0)), 16'($urandom), 17'($urandom_range(65536, 0)));
    random_phase(80, 1'b0);

    $display("summary: %0d input transfers, %0d readout rows checked, 7 register settings",
             sent_items, sb.rows_checked);
    $display("summary: corner cases, back-to-back reads, output hold-off, random reads");
    if (sb.mismatches == 0 && sb.expected_rows.size() == 0) begin
      $display("pileup_base_counter_iupac_core verification clean");
    end else begin
      $display("pileup_base_counter_iupac_core verification failed");
    end
    $finish;
  end

endmodule
